// ===== rtl/core/icmpv6_nd_option_parser_defines.svh =====
// Assertion macros used by the checker of the ND option parser.
`ifndef ICMPV6_ND_OPTION_PARSER_DEFINES_SVH
`define ICMPV6_ND_OPTION_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and quiet during reset.
`define ICMPND_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock and quiet during reset.
`define ICMPND_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/icmpnd_pkg.sv =====
// Types and constants of the ICMPv6 Neighbor Discovery option parser.
`timescale 1ns / 1ps

package icmpnd_pkg;

    localparam logic [2:0] KIND_LINK   = 3'd0;
    localparam logic [2:0] KIND_PREFIX = 3'd1;
    localparam logic [2:0] KIND_REDIR  = 3'd2;
    localparam logic [2:0] KIND_MTU    = 3'd3;
    localparam logic [2:0] KIND_RAW    = 3'd4;
    localparam logic [2:0] KIND_TRUNC  = 3'd5;
    localparam logic [2:0] KIND_ZERO   = 3'd6;

    localparam logic [7:0] TYPE_SRC_LINK = 8'd1;
    localparam logic [7:0] TYPE_TGT_LINK = 8'd2;
    localparam logic [7:0] TYPE_PREFIX   = 8'd3;
    localparam logic [7:0] TYPE_REDIR    = 8'd4;
    localparam logic [7:0] TYPE_MTU      = 8'd5;

    localparam logic [10:0] PREFIX_BODY = 11'd30;
    localparam logic [10:0] MTU_BODY    = 11'd6;

    typedef struct packed {
        logic [7:0]  opt_type;
        logic [7:0]  opt_len_units;
        logic [2:0]  kind;
        logic [7:0]  prefix_length;
        logic        on_link_flag;
        logic        autonomous_flag;
        logic [31:0] valid_lifetime;
        logic [31:0] preferred_lifetime;
        logic [63:0] prefix_upper;
        logic [63:0] prefix_lower;
        logic [31:0] mtu_value;
        logic        final_option;
    } t_result;

endpackage

// ===== rtl/core/icmpnd_result_skid.sv =====
// Two-entry output stage for option results: head register plus skid register.
`timescale 1ns / 1ps

module icmpnd_result_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  icmpnd_pkg::t_result i_res,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_stall,
    output icmpnd_pkg::t_result o_res
);
    import icmpnd_pkg::*;

    logic    r_head_v, n_head_v;
    logic    r_skid_v, n_skid_v;
    t_result r_head, n_head;
    t_result r_skid, n_skid;
    logic    w_pop;

    // A push only arrives while the skid entry is free, since o_full stalls the source.
    assign w_pop = r_head_v && !i_stall;

    always_comb begin
        n_head_v = r_head_v;
        n_skid_v = r_skid_v;
        n_head   = r_head;
        n_skid   = r_skid;
        if (w_pop) begin
            if (r_skid_v) begin
                n_head   = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_head   = i_res;
                n_head_v = i_push;
            end
        end else if (i_push) begin
            if (!r_head_v) begin
                n_head   = i_res;
                n_head_v = 1'b1;
            end else begin
                n_skid   = i_res;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_head_v <= n_head_v;
            r_skid_v <= n_skid_v;
        end
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_head_v;
    assign o_res   = r_head;

endmodule

// ===== rtl/core/icmpv6_nd_option_parser.sv =====
// Top level of the ICMPv6 Neighbor Discovery option parser.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake            Payload
//  input     in         i_valid / o_stall    i_data_byte, i_final_byte
//  result    out        o_valid / i_stall    o_opt_type ... o_final_option
//
//  One byte is taken per clock cycle while o_stall is low. Each byte updates
//  the parse state in the same cycle it is accepted; a result it produces is
//  registered in the head entry of the output stage, or in its skid entry if stalled.
//  o_stall rises only when both output entries hold results, so a stalled output
//  costs no input cycles until the skid entry is used as well.
//  Reset is synchronous and active low; it returns the parser to the type byte and
//  empties the output stage.
//
// The parser walks type / length records of the options area. The length counts
// 8-byte units including the two header bytes, so the body of an option is
// units * 8 - 2 bytes long. Body bytes of prefix information and MTU options are
// shifted into accumulators by their position in the body, and the result of an
// option is formed when its body ends or when the capture ends early. A zero
// length ends the useful part of the packet: the remaining bytes are dropped.

module icmpv6_nd_option_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_opt_type,
    output logic [7:0]  o_opt_len_units,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_prefix_length,
    output logic        o_on_link_flag,
    output logic        o_autonomous_flag,
    output logic [31:0] o_valid_lifetime,
    output logic [31:0] o_preferred_lifetime,
    output logic [63:0] o_prefix_upper,
    output logic [63:0] o_prefix_lower,
    output logic [31:0] o_mtu_value,
    output logic        o_final_option
);
    import icmpnd_pkg::*;

    // Parse phases, one-hot.
    typedef enum logic [3:0] {
        PH_TYPE = 4'b0001,
        PH_LEN  = 4'b0010,
        PH_BODY = 4'b0100,
        PH_SKIP = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_held_type, n_held_type;
    logic [7:0]  r_held_units, n_held_units;
    logic [10:0] r_body_index, n_body_index;
    logic [63:0] r_lifetime, n_lifetime;
    logic [63:0] r_prefix_hi, n_prefix_hi;
    logic [63:0] r_prefix_lo, n_prefix_lo;
    logic [41:0] r_misc, n_misc;

    logic        w_accept;
    logic        w_full;
    logic        w_emit;
    logic [10:0] w_body_len;
    logic [7:0]  w_res_type;
    logic [7:0]  w_res_units;
    logic [2:0]  w_res_kind;
    logic        w_res_final;
    t_result     w_res;
    t_result     w_out;

    // Kind of a finished option. A complete body is needed for link address and
    // redirected header; prefix information and MTU only need their fixed fields.
    function automatic logic [2:0] option_kind(
        input logic [7:0]  typ,
        input logic        complete,
        input logic [10:0] got,
        input logic [10:0] blen
    );
        logic [2:0] k;
        unique case (typ)
            TYPE_SRC_LINK, TYPE_TGT_LINK: k = complete ? KIND_LINK : KIND_RAW;
            TYPE_PREFIX: k = (blen >= PREFIX_BODY && got >= PREFIX_BODY) ? KIND_PREFIX
                                                                          : KIND_RAW;
            TYPE_REDIR:  k = complete ? KIND_REDIR : KIND_RAW;
            TYPE_MTU:    k = (got >= MTU_BODY) ? KIND_MTU : KIND_RAW;
            default:     k = KIND_RAW;
        endcase
        return k;
    endfunction

    assign w_accept   = i_valid && !w_full;
    assign w_body_len = {r_held_units, 3'b000} - 11'd2;

    always_comb begin
        n_phase      = r_phase;
        n_held_type  = r_held_type;
        n_held_units = r_held_units;
        n_body_index = r_body_index;
        n_lifetime   = r_lifetime;
        n_prefix_hi  = r_prefix_hi;
        n_prefix_lo  = r_prefix_lo;
        n_misc       = r_misc;
        w_emit       = 1'b0;
        w_res_type   = r_held_type;
        w_res_units  = r_held_units;
        w_res_kind   = KIND_RAW;
        w_res_final  = 1'b1;

        if (w_accept) begin
            unique case (r_phase)
                PH_TYPE: begin
                    n_held_type  = i_data_byte;
                    n_held_units = 8'd0;
                    n_body_index = 11'd0;
                    n_lifetime   = 64'd0;
                    n_prefix_hi  = 64'd0;
                    n_prefix_lo  = 64'd0;
                    n_misc       = 42'd0;
                    if (i_final_byte) begin
                        // Capture ended on the type byte: truncated header.
                        w_emit      = 1'b1;
                        w_res_type  = i_data_byte;
                        w_res_units = 8'd0;
                        w_res_kind  = KIND_TRUNC;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_held_units = i_data_byte;
                    w_res_units  = i_data_byte;
                    if (i_data_byte == 8'd0) begin
                        w_emit     = 1'b1;
                        w_res_kind = KIND_ZERO;
                        n_phase    = i_final_byte ? PH_TYPE : PH_SKIP;
                    end else if (i_final_byte) begin
                        // No body byte arrived, so every type reports as raw.
                        w_emit     = 1'b1;
                        w_res_kind = option_kind(r_held_type, 1'b0, 11'd0,
                                                 {i_data_byte, 3'b000} - 11'd2);
                        n_phase    = PH_TYPE;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    // Fixed fields by body position: prefix length, flags,
                    // MTU or lifetimes, reserved word, then the prefix.
                    if (r_body_index == 11'd0) begin
                        n_misc[39:32] = i_data_byte;
                    end else if (r_body_index == 11'd1) begin
                        n_misc[40] = i_data_byte[7];
                        n_misc[41] = i_data_byte[6];
                    end
                    if (r_body_index >= 11'd2 && r_body_index <= 11'd5) begin
                        n_misc[31:0] = {r_misc[23:0], i_data_byte};
                    end
                    if (r_body_index >= 11'd2 && r_body_index <= 11'd9) begin
                        n_lifetime = {r_lifetime[55:0], i_data_byte};
                    end else if (r_body_index >= 11'd14 && r_body_index <= 11'd21) begin
                        n_prefix_hi = {r_prefix_hi[55:0], i_data_byte};
                    end else if (r_body_index >= 11'd22 && r_body_index <= 11'd29) begin
                        n_prefix_lo = {r_prefix_lo[55:0], i_data_byte};
                    end
                    n_body_index = r_body_index + 11'd1;
                    if (n_body_index == w_body_len) begin
                        w_emit      = 1'b1;
                        w_res_kind  = option_kind(r_held_type, 1'b1, n_body_index,
                                                  w_body_len);
                        w_res_final = i_final_byte;
                        n_phase     = PH_TYPE;
                    end else if (i_final_byte) begin
                        w_emit     = 1'b1;
                        w_res_kind = option_kind(r_held_type, 1'b0, n_body_index,
                                                 w_body_len);
                        n_phase    = PH_TYPE;
                    end
                end
                PH_SKIP: begin
                    if (i_final_byte) begin
                        n_phase = PH_TYPE;
                    end
                end
                default: begin
                    n_phase = PH_TYPE;
                end
            endcase
        end
    end

    // Decoded fields are shown only for the kind they belong to, else zero.
    always_comb begin
        w_res               = '0;
        w_res.opt_type      = w_res_type;
        w_res.opt_len_units = w_res_units;
        w_res.kind          = w_res_kind;
        w_res.final_option  = w_res_final;
        if (w_res_kind == KIND_PREFIX) begin
            w_res.prefix_length      = n_misc[39:32];
            w_res.on_link_flag       = n_misc[40];
            w_res.autonomous_flag    = n_misc[41];
            w_res.valid_lifetime     = n_lifetime[63:32];
            w_res.preferred_lifetime = n_lifetime[31:0];
            w_res.prefix_upper       = n_prefix_hi;
            w_res.prefix_lower       = n_prefix_lo;
        end
        if (w_res_kind == KIND_MTU) begin
            w_res.mtu_value = n_misc[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
        end else begin
            r_phase <= n_phase;
        end
        r_held_type  <= n_held_type;
        r_held_units <= n_held_units;
        r_body_index <= n_body_index;
        r_lifetime   <= n_lifetime;
        r_prefix_hi  <= n_prefix_hi;
        r_prefix_lo  <= n_prefix_lo;
        r_misc       <= n_misc;
    end

    icmpnd_result_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_emit),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_out)
    );

    assign o_stall              = w_full;
    assign o_opt_type           = w_out.opt_type;
    assign o_opt_len_units      = w_out.opt_len_units;
    assign o_kind               = w_out.kind;
    assign o_prefix_length      = w_out.prefix_length;
    assign o_on_link_flag       = w_out.on_link_flag;
    assign o_autonomous_flag    = w_out.autonomous_flag;
    assign o_valid_lifetime     = w_out.valid_lifetime;
    assign o_preferred_lifetime = w_out.preferred_lifetime;
    assign o_prefix_upper       = w_out.prefix_upper;
    assign o_prefix_lower       = w_out.prefix_lower;
    assign o_mtu_value          = w_out.mtu_value;
    assign o_final_option       = w_out.final_option;

endmodule

// ===== rtl/core/icmpnd_checker.sv =====
// Port-level checker of the ND option parser and its bind to the top level.
`timescale 1ns / 1ps
`include "icmpv6_nd_option_parser_defines.svh"

module icmpnd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_opt_type,
    input logic [7:0]  o_opt_len_units,
    input logic [2:0]  o_kind,
    input logic [7:0]  o_prefix_length,
    input logic        o_on_link_flag,
    input logic        o_autonomous_flag,
    input logic [31:0] o_valid_lifetime,
    input logic [31:0] o_preferred_lifetime,
    input logic [63:0] o_prefix_upper,
    input logic [63:0] o_prefix_lower,
    input logic [31:0] o_mtu_value,
    input logic        o_final_option
);
    import icmpnd_pkg::*;

    logic        w_held;
    logic [10:0] w_key;
    logic        w_no_pfx;
    logic        w_pfx_clr;
    logic        w_no_mtu;
    logic        w_stop;
    logic        w_stop_ok;

    assign w_held    = o_valid && i_stall;
    assign w_key     = {o_opt_type, o_kind};
    assign w_no_pfx  = o_valid && (o_kind != KIND_PREFIX);
    assign w_pfx_clr = (o_prefix_length == 8'd0) && !o_on_link_flag && !o_autonomous_flag
                       && (o_valid_lifetime == 32'd0) && (o_preferred_lifetime == 32'd0)
                       && (o_prefix_upper == 64'd0) && (o_prefix_lower == 64'd0);
    assign w_no_mtu  = o_valid && (o_kind != KIND_MTU);
    assign w_stop    = o_valid && (o_kind == KIND_TRUNC || o_kind == KIND_ZERO);
    assign w_stop_ok = o_final_option && (o_opt_len_units == 8'd0);

    // A result held by a stall keeps its type and kind.
    `ICMPND_ASSERT_NEXT(a_out_hold, w_held, o_valid && $stable(w_key), "stalled result changed")

    // Prefix fields are zero on every result that is not prefix information.
    `ICMPND_ASSERT_NOW(a_prefix_zero, w_no_pfx, w_pfx_clr, "prefix data outside prefix info")

    // The MTU field is zero on every result that is not an MTU option.
    `ICMPND_ASSERT_NOW(a_mtu_zero, w_no_mtu, o_mtu_value == 32'd0, "mtu set outside mtu option")

    // Truncated headers and zero lengths end the packet and report no length.
    `ICMPND_ASSERT_NOW(a_stop_final, w_stop, w_stop_ok, "stop result without final mark")

endmodule

bind icmpv6_nd_option_parser icmpnd_checker u_checker (.*);
